@@ design/lfr_pkg.sv @@
package lfr_pkg;

	localparam int FRAME_W = 6;
	localparam int CNT_W = 7;
	localparam int OP_W = 2;
	localparam int MAX_CELLS = 2 ** FRAME_W;
	localparam int LFR_NUM_FRAMES = 64;

	localparam logic [OP_W-1:0] OP_VICTIM = 2'd0;
	localparam logic [OP_W-1:0] OP_PIN = 2'd1;
	localparam logic [OP_W-1:0] OP_UNPIN = 2'd2;

	typedef struct packed {
		logic [OP_W-1:0] op;
		logic [FRAME_W-1:0] frame;
	} lfr_req_t;

	typedef struct packed {
		logic victim_valid;
		logic [FRAME_W-1:0] victim_frame;
		logic [CNT_W-1:0] unpinned_count;
	} lfr_rsp_t;

	// update command broadcast to every cell of the row
	typedef struct packed {
		logic remove;
		logic append;
		logic [FRAME_W-1:0] pos;
		logic [CNT_W-1:0] count;
		logic [FRAME_W-1:0] frame;
	} lfr_ctrl_t;

endpackage

@@ design/lfr_cell.sv @@
module lfr_cell #(
	parameter int CELL_IDX = 0
) (
	input logic clk,
	input logic arst_n,
	input lfr_pkg::lfr_ctrl_t ctrl,
	input logic [lfr_pkg::FRAME_W-1:0] look_frame,
	input logic nxt_valid,
	input logic [lfr_pkg::FRAME_W-1:0] nxt_frame,
	output logic valid_q,
	output logic [lfr_pkg::FRAME_W-1:0] frame_q,
	output logic match
);
	import lfr_pkg::*;

	logic take_nxt;
	logic load;

	// everything at or behind the removed slot moves one place toward the head
	assign take_nxt = ctrl.remove && (CNT_W'(CELL_IDX) >= CNT_W'(ctrl.pos));
	assign load = ctrl.append && (CNT_W'(CELL_IDX) == ctrl.count);
	assign match = valid_q && (frame_q == look_frame);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (take_nxt) begin
			valid_q <= nxt_valid;
		end else if (load) begin
			valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (take_nxt) begin
			frame_q <= nxt_frame;
		end else if (load) begin
			frame_q <= ctrl.frame;
		end
	end

endmodule

@@ design/lru_frame_replacer_top.sv @@
// The result word is registered at the end of the update state and strobed on done.
// Each request passes a lookup state (match across the cell row) and then an update
// state (the row shifts or loads); a new one may be taken in update; busy is high in lookup.
// Reset: every frame pinned, LRU list empty, count zero; no clearing pass needed.
// The receiver cannot stall: done is high for exactly one cycle per request.
module lru_frame_replacer_top #(
	parameter int NUM_FRAMES = lfr_pkg::LFR_NUM_FRAMES
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input lfr_pkg::lfr_req_t req,
	output logic done,
	output lfr_pkg::lfr_rsp_t rsp
);
	import lfr_pkg::*;

	// frame numbers are FRAME_W bits wide, so no more cells than that can reach
	localparam int NCELL = (NUM_FRAMES < MAX_CELLS) ? NUM_FRAMES : MAX_CELLS;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_LOOK = 2'd1;
	localparam logic [1:0] ST_UPD = 2'd2;

	logic [1:0] st_q;
	lfr_req_t req_q;
	logic rm_s1;
	logic app_s1;
	logic [FRAME_W-1:0] pos_s1;
	logic vvalid_s1;
	logic [FRAME_W-1:0] vframe_s1;
	logic [CNT_W-1:0] count_q;
	logic done_q;
	lfr_rsp_t rsp_q;

	lfr_ctrl_t ctrl;
	logic [NCELL-1:0] cell_valid;
	logic [FRAME_W-1:0] cell_frame [NCELL];
	logic [NCELL-1:0] match_vec;

	logic found;
	logic [FRAME_W-1:0] enc_pos;
	logic in_range;
	logic rm_d;
	logic app_d;
	logic [FRAME_W-1:0] pos_d;
	logic vvalid_d;
	logic [FRAME_W-1:0] vframe_d;
	logic [CNT_W-1:0] count_d;
	logic accept;

	assign busy = (st_q == ST_LOOK);
	assign accept = start && !busy;
	assign done = done_q;
	assign rsp = rsp_q;

	assign ctrl.remove = rm_s1 && (st_q == ST_UPD);
	assign ctrl.append = app_s1 && (st_q == ST_UPD);
	assign ctrl.pos = pos_s1;
	assign ctrl.count = count_q;
	assign ctrl.frame = req_q.frame;

	for (genvar i = 0; i < NCELL; i++) begin : g_cell
		logic nv;
		logic [FRAME_W-1:0] nf;
		if (i == NCELL - 1) begin : g_last
			assign nv = 1'b0;
			assign nf = '0;
		end else begin : g_mid
			assign nv = cell_valid[i+1];
			assign nf = cell_frame[i+1];
		end
		lfr_cell #(
			.CELL_IDX(i)
		) u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.ctrl(ctrl),
			.look_frame(req_q.frame),
			.nxt_valid(nv),
			.nxt_frame(nf),
			.valid_q(cell_valid[i]),
			.frame_q(cell_frame[i]),
			.match(match_vec[i])
		);
	end

	// match is one-hot at most, so an OR of indexes encodes it
	always_comb begin
		found = 1'b0;
		enc_pos = '0;
		for (int i = 0; i < NCELL; i++) begin
			if (match_vec[i]) begin
				found = 1'b1;
				enc_pos = enc_pos | FRAME_W'(i);
			end
		end
	end

	assign in_range = 32'(req_q.frame) < NUM_FRAMES;

	always_comb begin
		rm_d = 1'b0;
		app_d = 1'b0;
		pos_d = '0;
		vvalid_d = 1'b0;
		vframe_d = '0;
		unique case (req_q.op)
			OP_VICTIM: begin
				rm_d = (count_q != '0);
				vvalid_d = (count_q != '0);
				vframe_d = (count_q != '0) ? cell_frame[0] : '0;
			end
			OP_PIN: begin
				rm_d = in_range && found;
				pos_d = enc_pos;
			end
			OP_UNPIN: begin
				app_d = in_range && !found;
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		count_d = count_q;
		if (rm_s1) begin
			count_d = count_q - CNT_W'(1);
		end else if (app_s1) begin
			count_d = count_q + CNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			rm_s1 <= 1'b0;
			app_s1 <= 1'b0;
			count_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (st_q)
				ST_IDLE: begin
					if (accept) begin
						st_q <= ST_LOOK;
					end
				end
				ST_LOOK: begin
					rm_s1 <= rm_d;
					app_s1 <= app_d;
					st_q <= ST_UPD;
				end
				ST_UPD: begin
					count_q <= count_d;
					done_q <= 1'b1;
					st_q <= accept ? ST_LOOK : ST_IDLE;
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= req;
		end
		if (st_q == ST_LOOK) begin
			pos_s1 <= pos_d;
			vvalid_s1 <= vvalid_d;
			vframe_s1 <= vframe_d;
		end
		if (st_q == ST_UPD) begin
			rsp_q.victim_valid <= vvalid_s1;
			rsp_q.victim_frame <= vframe_s1;
			rsp_q.unpinned_count <= count_d;
		end
	end

	a_count_matches_cells: assert property (@(posedge clk) disable iff (!arst_n)
		CNT_W'($countones(cell_valid)) == count_q)
		else $error("occupied cell count differs from unpinned count");

	a_match_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(match_vec))
		else $error("frame found in more than one cell");

	a_no_rm_and_app: assert property (@(posedge clk) disable iff (!arst_n)
		!(rm_s1 && app_s1))
		else $error("remove and append issued together");

	a_done_after_upd: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(st_q == ST_UPD))
		else $error("result strobe without an update cycle");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(NCELL))
		else $error("unpinned count beyond cell row");

endmodule

@@ tb/lru_replacer_checker.sv @@
module lru_replacer_checker #(
	parameter int NUM_FRAMES = lfr_pkg::LFR_NUM_FRAMES
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input lfr_pkg::lfr_req_t req,
	input logic done,
	input lfr_pkg::lfr_rsp_t rsp,
	output int errors,
	output int pending
);
	timeunit 1ns;
	timeprecision 1ps;

	import lfr_pkg::*;

	logic pinned [NUM_FRAMES];
	// head = least recently unpinned frame
	logic [FRAME_W-1:0] lru_order [$];
	lfr_rsp_t predicted_rsp_q [$];

	initial begin
		errors = 0;
		pending = 0;
		foreach (pinned[i])
			pinned[i] = 1'b1;
	end

	function automatic lfr_rsp_t apply_frame_op(input lfr_req_t r);
		lfr_rsp_t res;
		int idx;
		res = '0;
		idx = 0;
		case (r.op)
		OP_VICTIM: begin
			if (lru_order.size() != 0) begin
				res.victim_valid = 1'b1;
				res.victim_frame = lru_order.pop_front();
				pinned[res.victim_frame] = 1'b1;
			end
		end
		OP_PIN: begin
			if (r.frame < NUM_FRAMES && !pinned[r.frame]) begin
				for (int i = 0; i < lru_order.size(); i++)
					if (lru_order[i] == r.frame)
						idx = i;
				lru_order.delete(idx);
				pinned[r.frame] = 1'b1;
			end
		end
		OP_UNPIN: begin
			// already unpinned frames keep their place
			if (r.frame < NUM_FRAMES && pinned[r.frame]) begin
				pinned[r.frame] = 1'b0;
				lru_order.insert(lru_order.size(), r.frame);
			end
		end
		default: ;
		endcase
		res.unpinned_count = CNT_W'(lru_order.size());
		return res;
	endfunction

	always @(posedge clk) begin
		lfr_rsp_t want;
		if (arst_n) begin
			// a word strobed at this edge belongs to an earlier request
			if (done) begin
				if (predicted_rsp_q.size() == 0) begin
					$error("result word with nothing expected: %p", rsp);
					errors++;
				end else begin
					want = predicted_rsp_q.pop_front();
					if (rsp.victim_valid !== want.victim_valid) begin
						$error("victim_valid: expected %0d, got %0d",
							want.victim_valid, rsp.victim_valid);
						errors++;
					end
					if (rsp.victim_frame !== want.victim_frame) begin
						$error("victim_frame: expected %0d, got %0d",
							want.victim_frame, rsp.victim_frame);
						errors++;
					end
					if (rsp.unpinned_count !== want.unpinned_count) begin
						$error("unpinned_count: expected %0d, got %0d",
							want.unpinned_count, rsp.unpinned_count);
						errors++;
					end
				end
			end
			if (start && !busy)
				predicted_rsp_q.insert(predicted_rsp_q.size(), apply_frame_op(req));
			pending = predicted_rsp_q.size();
		end
	end

endmodule

@@ tb/tb_lru_frame_replacer_top.sv @@
module tb_lru_frame_replacer_top;
	timeunit 1ns;
	timeprecision 1ps;

	import lfr_pkg::*;

	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
	localparam int NUM_RANDOM = 1250;

	typedef enum int {MODE_FILL, MODE_DRAIN, MODE_MIXED, MODE_SWEEP} stim_mode_t;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	lfr_req_t req;
	logic done;
	lfr_rsp_t rsp;
	int errors;
	int pending;

	logic no_idle;
	logic [FRAME_W-1:0] recent_unpins [$];

	lru_frame_replacer_top u_top (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req(req),
		.done(done),
		.rsp(rsp)
	);

	lru_replacer_checker u_check (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req(req),
		.done(done),
		.rsp(rsp),
		.errors(errors),
		.pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5ms;
		$display("** lru_frame_replacer_top: FAILED **");
		$finish;
	end

	// holds the word on req until an edge with busy low takes it
	task automatic issue_request(input logic [OP_W-1:0] op, input logic [FRAME_W-1:0] frame);
		int gap;
		logic free_at_edge;
		lfr_req_t w;
		gap = no_idle ? 0 : $urandom_range(0, 8);
		w.op = op;
		w.frame = frame;
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		req <= w;
		do begin
			@(negedge clk);
			free_at_edge = !busy;
			@(posedge clk);
		end while (!free_at_edge);
	endtask

	task automatic drain_results();
		start <= 1'b0;
		do
			@(negedge clk);
		while (pending != 0);
		@(posedge clk);
	endtask

	initial begin
		stim_mode_t mode;
		int roll;
		logic [OP_W-1:0] op;
		logic [FRAME_W-1:0] frame;
		logic [FRAME_W-1:0] sweep_frame;
		int wait_cycles;

		start = 1'b0;
		req = '0;
		arst_n = 1'b0;
		no_idle = 1'b0;
		mode = MODE_FILL;
		sweep_frame = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty list, no-op pin, unused op
		issue_request(OP_VICTIM, 6'd0);
		issue_request(OP_PIN, 6'd5);
		issue_request(OP_UNUSED, 6'd63);
		// second unpin of 0 must not move it to the tail
		issue_request(OP_UNPIN, 6'd0);
		issue_request(OP_UNPIN, 6'd63);
		issue_request(OP_UNPIN, 6'd0);
		issue_request(OP_UNPIN, 6'd21);
		issue_request(OP_UNPIN, 6'd42);
		issue_request(OP_VICTIM, 6'd63);
		// remove from middle, tail, then the last one left
		issue_request(OP_PIN, 6'd21);
		issue_request(OP_PIN, 6'd42);
		issue_request(OP_PIN, 6'd63);
		issue_request(OP_VICTIM, 6'd0);
		issue_request(OP_UNPIN, 6'd7);
		issue_request(OP_PIN, 6'd7);
		issue_request(OP_UNPIN, 6'd1);
		issue_request(OP_UNPIN, 6'd2);
		issue_request(OP_UNPIN, 6'd3);
		issue_request(OP_VICTIM, 6'd0);
		issue_request(OP_UNPIN, 6'd1);
		issue_request(OP_VICTIM, 6'd0);
		issue_request(OP_VICTIM, 6'd0);
		issue_request(OP_VICTIM, 6'd0);
		issue_request(OP_VICTIM, 6'd0);
		drain_results();

		for (int n = 0; n < NUM_RANDOM; n++) begin
			if (n % 60 == 0)
				no_idle = ($urandom_range(0, 3) == 0);
			if (n % 100 == 0)
				mode = stim_mode_t'($urandom_range(0, 3));
			if (n % 250 == 249)
				drain_results();
			roll = $urandom_range(0, 99);
			case (mode)
			MODE_FILL: op = roll < 65 ? OP_UNPIN : roll < 80 ? OP_PIN :
				roll < 96 ? OP_VICTIM : OP_UNUSED;
			MODE_DRAIN: op = roll < 15 ? OP_UNPIN : roll < 45 ? OP_PIN :
				roll < 96 ? OP_VICTIM : OP_UNUSED;
			MODE_SWEEP: op = roll < 85 ? OP_UNPIN : roll < 92 ? OP_PIN : OP_VICTIM;
			default: op = roll < 35 ? OP_UNPIN : roll < 65 ? OP_PIN :
				roll < 96 ? OP_VICTIM : OP_UNUSED;
			endcase
			frame = FRAME_W'($urandom_range(0, MAX_CELLS - 1));
			if (op == OP_UNPIN) begin
				// sweep walks every frame so the list can fill up completely
				if (mode == MODE_SWEEP) begin
					frame = sweep_frame;
					sweep_frame++;
				end
				recent_unpins.insert(recent_unpins.size(), frame);
				if (recent_unpins.size() > 16)
					void'(recent_unpins.pop_front());
			end else if (op == OP_PIN && recent_unpins.size() != 0
					&& $urandom_range(0, 99) < 70) begin
				frame = recent_unpins[$urandom_range(0, recent_unpins.size() - 1)];
			end
			issue_request(op, frame);
		end

		start <= 1'b0;
		wait_cycles = 0;
		do begin
			@(negedge clk);
			wait_cycles++;
		end while (pending != 0 && wait_cycles < 200);
		repeat (4) @(posedge clk);
		if (pending != 0)
			$error("%0d result words never arrived", pending);
		if (errors == 0 && pending == 0)
			$display("** lru_frame_replacer_top: PASSED **");
		else
			$display("** lru_frame_replacer_top: FAILED **");
		$finish;
	end

endmodule

@@ lru_frame_replacer_top.f @@
design/lfr_pkg.sv
design/lfr_cell.sv
design/lru_frame_replacer_top.sv
tb/lru_replacer_checker.sv
tb/tb_lru_frame_replacer_top.sv
